### rtl/core/snip_pkg.sv
// shared types and constants for the server-name extension parser
// no dependencies; imported by every module of the block
package snip_pkg;

    localparam int unsigned MAX_NAMES_DEF    = 4;
    localparam int unsigned MAX_NAME_LEN_DEF = 256;

    // a single input word gives at most a name byte, an end marker and a summary
    localparam int unsigned RES_MAX    = 3;
    localparam int unsigned FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_NAME_BYTE = 2'd0,
        KIND_NAME_END  = 2'd1,
        KIND_SUMMARY   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_ACCEPTED     = 2'd0,
        ST_IGNORED      = 2'd1,
        ST_LEN_MISMATCH = 2'd2,
        ST_OVERRUN      = 2'd3
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  slot;
        logic [7:0]  byte_offset;
        logic [7:0]  name_byte;
        logic [8:0]  name_size;
        t_status     status;
        logic [2:0]  name_count;
        logic        count_capped;
        logic        final_result;
    } t_result;

    // results produced by one accepted word, packed from index 0
    typedef struct packed {
        logic [1:0]                count;
        t_result [RES_MAX-1:0]     res;
    } t_push;

endpackage

### rtl/core/snip_parser.sv
// parse state machine: updates the parse state for one word and forms its results
// depends on snip_pkg
module snip_parser
    import snip_pkg::*;
#(
    parameter int unsigned MAX_NAMES    = MAX_NAMES_DEF,
    parameter int unsigned MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_take,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_last,
    output t_push       o_push
);

    localparam int unsigned CW = $clog2(MAX_NAMES + 2);
    localparam logic [CW-1:0] NAMES_C    = CW'(MAX_NAMES);
    localparam logic [CW-1:0] NAMES_P1   = CW'(MAX_NAMES + 1);
    localparam logic [16:0]   NAME_LEN_C = 17'(MAX_NAME_LEN);
    localparam logic [16:0]   BA_MAX     = 17'h1FFFF;

    typedef enum logic [5:0] {
        PH_LIST_HI = 6'b000001,
        PH_LIST_LO = 6'b000010,
        PH_TYPE    = 6'b000100,
        PH_LEN_HI  = 6'b001000,
        PH_LEN_LO  = 6'b010000,
        PH_NAME    = 6'b100000
    } t_phase;

    t_phase          r_phase, n_phase;
    logic            r_role, n_role;
    logic [15:0]     r_list, n_list;
    logic [16:0]     r_ba, n_ba;
    logic [CW-1:0]   r_pos, n_pos;
    logic            r_type_zero, n_type_zero;
    logic [15:0]     r_rec_len, n_rec_len;
    logic [15:0]     r_left, n_left;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_overrun, n_overrun;

    logic [15:0]     rec_len_full;
    logic [15:0]     cur_len;
    logic            eligible;
    logic [16:0]     ba_inc;
    logic [CW-1:0]   pos_inc;
    logic [15:0]     left_dec;
    logic            overrun_now;
    logic            f_byte, f_end, f_sum, clear;
    t_result         res_byte, res_end, res_sum;

    always_comb begin
        rec_len_full = {r_rec_len[15:8], i_data_byte};
        cur_len      = (r_phase == PH_LEN_LO) ? rec_len_full : r_rec_len;
        eligible     = r_type_zero && ({1'b0, cur_len} <= NAME_LEN_C) && (r_pos < NAMES_C);
        ba_inc       = (r_ba < BA_MAX) ? r_ba + 17'd1 : r_ba;
        pos_inc      = (r_pos < NAMES_C) ? r_pos + CW'(1) : r_pos;
        left_dec     = r_left - 16'd1;
        // declared length against what is left of the list
        if (ba_inc <= {1'b0, r_list}) begin
            overrun_now = {1'b0, rec_len_full} > ({1'b0, r_list} - ba_inc);
        end else begin
            overrun_now = (rec_len_full != 16'd0);
        end

        res_byte             = '0;
        res_byte.kind        = KIND_NAME_BYTE;
        res_byte.slot        = 2'(r_pos);
        res_byte.byte_offset = 8'(r_rec_len - r_left);
        res_byte.name_byte   = i_data_byte;

        res_end              = '0;
        res_end.kind         = KIND_NAME_END;
        res_end.slot         = 2'(r_pos);
        res_end.name_size    = cur_len[8:0];

        res_sum              = '0;
        res_sum.kind         = KIND_SUMMARY;
        res_sum.final_result = 1'b1;

        n_role      = i_cfg_we ? i_cfg_wdata : r_role;
        n_phase     = r_phase;
        n_list      = r_list;
        n_ba        = r_ba;
        n_pos       = r_pos;
        n_type_zero = r_type_zero;
        n_rec_len   = r_rec_len;
        n_left      = r_left;
        n_cnt       = r_cnt;
        n_overrun   = r_overrun;
        f_byte      = 1'b0;
        f_end       = 1'b0;
        f_sum       = 1'b0;
        clear       = 1'b0;

        if (i_take) begin
            if (!r_role) begin
                if (i_is_last) begin
                    f_sum          = 1'b1;
                    res_sum.status = ST_IGNORED;
                    clear          = 1'b1;
                end
            end else begin
                case (r_phase)
                    PH_LIST_HI: begin
                        n_list  = {i_data_byte, 8'h00};
                        n_phase = PH_LIST_LO;
                    end
                    PH_LIST_LO: begin
                        n_list  = {r_list[15:8], i_data_byte};
                        n_phase = PH_TYPE;
                    end
                    PH_TYPE: begin
                        n_ba        = ba_inc;
                        n_type_zero = (i_data_byte == 8'h00);
                        n_phase     = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        n_ba      = ba_inc;
                        n_rec_len = {i_data_byte, 8'h00};
                        n_phase   = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_ba      = ba_inc;
                        n_rec_len = rec_len_full;
                        if (overrun_now) begin
                            n_overrun = 1'b1;
                        end
                        if (rec_len_full != 16'd0 && r_cnt < NAMES_P1) begin
                            n_cnt = r_cnt + CW'(1);
                        end
                        if (rec_len_full == 16'd0) begin
                            f_end   = eligible;
                            n_pos   = pos_inc;
                            n_phase = PH_TYPE;
                        end else begin
                            n_left  = rec_len_full;
                            n_phase = PH_NAME;
                        end
                    end
                    PH_NAME: begin
                        n_ba   = ba_inc;
                        f_byte = eligible;
                        n_left = left_dec;
                        if (left_dec == 16'd0) begin
                            f_end   = eligible;
                            n_pos   = pos_inc;
                            n_phase = PH_TYPE;
                        end
                    end
                    default: begin
                        n_phase = PH_LIST_HI;
                    end
                endcase

                if (i_is_last) begin
                    f_sum = 1'b1;
                    clear = 1'b1;
                    if (n_phase == PH_LIST_HI || n_phase == PH_LIST_LO ||
                        n_ba != {1'b0, n_list}) begin
                        res_sum.status = ST_LEN_MISMATCH;
                    end else if (n_overrun || n_phase != PH_TYPE) begin
                        res_sum.status = ST_OVERRUN;
                    end else begin
                        res_sum.status       = ST_ACCEPTED;
                        res_sum.name_count   = (n_cnt > NAMES_C) ? 3'(NAMES_C) : 3'(n_cnt);
                        res_sum.count_capped = (n_cnt > NAMES_C);
                    end
                end
            end
        end

        // every summary returns the parse state to its start
        if (clear) begin
            n_phase     = PH_LIST_HI;
            n_list      = '0;
            n_ba        = '0;
            n_pos       = '0;
            n_type_zero = 1'b1;
            n_rec_len   = '0;
            n_left      = '0;
            n_cnt       = '0;
            n_overrun   = 1'b0;
        end

        o_push.count  = {1'b0, f_byte} + {1'b0, f_end} + {1'b0, f_sum};
        o_push.res[0] = f_byte ? res_byte : (f_end ? res_end : res_sum);
        o_push.res[1] = f_byte ? (f_end ? res_end : res_sum) : res_sum;
        o_push.res[2] = res_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role      <= 1'b1;
            r_phase     <= PH_LIST_HI;
            r_list      <= '0;
            r_ba        <= '0;
            r_pos       <= '0;
            r_type_zero <= 1'b1;
            r_rec_len   <= '0;
            r_left      <= '0;
            r_cnt       <= '0;
            r_overrun   <= 1'b0;
        end else begin
            r_role      <= n_role;
            r_phase     <= n_phase;
            r_list      <= n_list;
            r_ba        <= n_ba;
            r_pos       <= n_pos;
            r_type_zero <= n_type_zero;
            r_rec_len   <= n_rec_len;
            r_left      <= n_left;
            r_cnt       <= n_cnt;
            r_overrun   <= n_overrun;
        end
    end

endmodule

### rtl/core/snip_result_fifo.sv
// result queue: takes up to three results per word, hands out one at a time as the reader takes them
// depends on snip_pkg
module snip_result_fifo
    import snip_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_push    i_push,
    output logic     o_in_ready,
    output logic     o_valid,
    input  logic     i_ready,
    output t_result  o_result
);

    localparam int unsigned PW = $clog2(FIFO_DEPTH);

    t_result         r_mem [FIFO_DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [PW:0]     r_count, n_count;
    logic            pop;

    // room for a full set of results, so no path from the output ready
    assign o_in_ready = (r_count <= (PW+1)'(FIFO_DEPTH - RES_MAX));
    assign o_valid    = (r_count != '0);
    assign o_result   = r_mem[r_rd];
    assign pop        = o_valid && i_ready;

    always_comb begin
        n_wr    = r_wr + PW'(i_push.count);
        n_rd    = r_rd + PW'(pop);
        n_count = r_count + (PW+1)'(i_push.count) - (PW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RES_MAX; k++) begin
            if (2'(k) < i_push.count) begin
                r_mem[r_wr + PW'(k)] <= i_push.res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

### rtl/core/sni_extension_parser_core.sv
// top level of the server-name extension parser: parser plus result queue
// depends on snip_pkg, snip_parser, snip_result_fifo
//
//   port group    dir   handshake              payload
//   input word    in    i_valid / o_ready      i_data_byte, i_is_last
//   result word   out   o_valid / i_ready      o_kind .. o_final_result
//   config        in    i_cfg_we               i_cfg_wdata (is_server_role)
//
// one input word is taken per cycle while o_ready is high; its results
// (up to three) enter a four-entry queue in the same cycle and leave one
// per cycle while i_ready is high; o_ready drops while the queue holds
// two or more results, so a word that yields several results can stall the input
// synchronous active-low reset; the role register resets to 1
module sni_extension_parser_core
    import snip_pkg::*;
#(
    parameter int unsigned MAX_NAMES    = MAX_NAMES_DEF,
    parameter int unsigned MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_slot,
    output logic [7:0]  o_byte_offset,
    output logic [7:0]  o_name_byte,
    output logic [8:0]  o_name_size,
    output logic [1:0]  o_status,
    output logic [2:0]  o_name_count,
    output logic        o_count_capped,
    output logic        o_final_result
);

    t_push    push;
    t_result  result;
    logic     take;

    assign take = i_valid && o_ready;

    snip_parser #(
        .MAX_NAMES    (MAX_NAMES),
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (take),
        .i_data_byte (i_data_byte),
        .i_is_last   (i_is_last),
        .o_push      (push)
    );

    snip_result_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_in_ready (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (result)
    );

    assign o_kind         = result.kind;
    assign o_slot         = result.slot;
    assign o_byte_offset  = result.byte_offset;
    assign o_name_byte    = result.name_byte;
    assign o_name_size    = result.name_size;
    assign o_status       = result.status;
    assign o_name_count   = result.name_count;
    assign o_count_capped = result.count_capped;
    assign o_final_result = result.final_result;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// testbench for sni_extension_parser_core: sends extension bodies one word at a time
// and checks every result word against an in-bench prediction of the parser
// depends on snip_pkg and the parser rtl only
module tb_top
    import snip_pkg::*;
;

    localparam int unsigned NAMES_MAX    = MAX_NAMES_DEF;
    localparam int unsigned NAME_LIMIT   = MAX_NAME_LEN_DEF;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned RAND_WORDS   = 240;
    localparam int unsigned REPORT_MAX   = 10;

    typedef enum logic [2:0] {
        PH_LEN_HI,
        PH_LEN_LO,
        PH_TYPE,
        PH_RLEN_HI,
        PH_RLEN_LO,
        PH_NAME
    } t_phase;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_is_last   = 1'b0;
    logic       i_ready     = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_kind;
    logic [1:0] o_slot;
    logic [7:0] o_byte_offset;
    logic [7:0] o_name_byte;
    logic [8:0] o_name_size;
    logic [1:0] o_status;
    logic [2:0] o_name_count;
    logic       o_count_capped;
    logic       o_final_result;

    sni_extension_parser_core #(
        .MAX_NAMES    (NAMES_MAX),
        .MAX_NAME_LEN (NAME_LIMIT)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_slot         (o_slot),
        .o_byte_offset  (o_byte_offset),
        .o_name_byte    (o_name_byte),
        .o_name_size    (o_name_size),
        .o_status       (o_status),
        .o_name_count   (o_name_count),
        .o_count_capped (o_count_capped),
        .o_final_result (o_final_result)
    );

    // predicted parser state
    bit          role_q;
    t_phase      phase_q;
    logic [15:0] list_len_q;
    int unsigned after_cnt_q;
    int unsigned rec_pos_q;
    logic [7:0]  rec_type_q;
    logic [15:0] rec_len_q;
    logic [15:0] rec_left_q;
    int unsigned nonempty_q;
    bit          overrun_q;

    t_result     expected_words[$];
    logic [7:0]  ext_body[$];
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned words_sent = 0;
    int unsigned err_cnt    = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void sni_clear_state();
        phase_q     = PH_LEN_HI;
        list_len_q  = '0;
        after_cnt_q = 0;
        rec_pos_q   = 0;
        rec_type_q  = '0;
        rec_len_q   = '0;
        rec_left_q  = '0;
        nonempty_q  = 0;
        overrun_q   = 1'b0;
    endfunction

    function automatic t_result result_word(t_kind k, int unsigned slot, int unsigned off,
                                            logic [7:0] nb, int unsigned nlen, t_status st,
                                            int unsigned cnt, bit capped, bit fin);
        t_result r;
        r.kind         = k;
        r.slot         = 2'(slot);
        r.byte_offset  = 8'(off);
        r.name_byte    = nb;
        r.name_size    = 9'(nlen);
        r.status       = st;
        r.name_count   = 3'(cnt);
        r.count_capped = capped;
        r.final_result = fin;
        return r;
    endfunction

    function automatic bit name_kept();
        return rec_type_q == 8'h00 && rec_len_q <= NAME_LIMIT && rec_pos_q < NAMES_MAX;
    endfunction

    function automatic void next_record();
        if (rec_pos_q < NAMES_MAX) rec_pos_q++;
        phase_q = PH_TYPE;
    endfunction

    function automatic void sni_predict_word(logic [7:0] d, bit last);
        int unsigned remaining;
        t_status     st;
        if (!role_q) begin
            if (last) begin
                expected_words.push_back(result_word(KIND_SUMMARY, 0, 0, 8'h00, 0,
                                                     ST_IGNORED, 0, 1'b0, 1'b1));
                sni_clear_state();
            end
            return;
        end
        case (phase_q)
            PH_LEN_HI: begin
                list_len_q = {d, 8'h00};
                phase_q    = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                list_len_q[7:0] = d;
                phase_q         = PH_TYPE;
            end
            default: begin
                if (after_cnt_q < 32'h1FFFF) after_cnt_q++;
                case (phase_q)
                    PH_TYPE: begin
                        rec_type_q = d;
                        phase_q    = PH_RLEN_HI;
                    end
                    PH_RLEN_HI: begin
                        rec_len_q = {d, 8'h00};
                        phase_q   = PH_RLEN_LO;
                    end
                    PH_RLEN_LO: begin
                        rec_len_q[7:0] = d;
                        remaining = (after_cnt_q <= list_len_q) ? list_len_q - after_cnt_q : 0;
                        if (rec_len_q > remaining) overrun_q = 1'b1;
                        if (rec_len_q != 0 && nonempty_q < NAMES_MAX + 1) nonempty_q++;
                        if (rec_len_q == 0) begin
                            if (name_kept())
                                expected_words.push_back(result_word(KIND_NAME_END, rec_pos_q,
                                    0, 8'h00, 0, ST_ACCEPTED, 0, 1'b0, 1'b0));
                            next_record();
                        end else begin
                            rec_left_q = rec_len_q;
                            phase_q    = PH_NAME;
                        end
                    end
                    default: begin
                        if (name_kept())
                            expected_words.push_back(result_word(KIND_NAME_BYTE, rec_pos_q,
                                rec_len_q - rec_left_q, d, 0, ST_ACCEPTED, 0, 1'b0, 1'b0));
                        rec_left_q = rec_left_q - 16'd1;
                        if (rec_left_q == 0) begin
                            if (name_kept())
                                expected_words.push_back(result_word(KIND_NAME_END, rec_pos_q,
                                    0, 8'h00, rec_len_q, ST_ACCEPTED, 0, 1'b0, 1'b0));
                            next_record();
                        end
                    end
                endcase
            end
        endcase
        if (last) begin
            // length check wins over the overrun check
            if (phase_q < PH_TYPE || after_cnt_q != list_len_q) st = ST_LEN_MISMATCH;
            else if (overrun_q || phase_q != PH_TYPE)            st = ST_OVERRUN;
            else                                                 st = ST_ACCEPTED;
            if (st == ST_ACCEPTED)
                expected_words.push_back(result_word(KIND_SUMMARY, 0, 0, 8'h00, 0, st,
                    (nonempty_q > NAMES_MAX) ? NAMES_MAX : nonempty_q,
                    nonempty_q > NAMES_MAX, 1'b1));
            else
                expected_words.push_back(result_word(KIND_SUMMARY, 0, 0, 8'h00, 0, st,
                    0, 1'b0, 1'b1));
            sni_clear_state();
        end
    endfunction

    // body builders: records first, then the list length goes in front
    function automatic void put_record(logic [7:0] rtype, int unsigned len);
        ext_body.push_back(rtype);
        ext_body.push_back(8'(len >> 8));
        ext_body.push_back(8'(len));
        repeat (len) ext_body.push_back(8'($urandom));
    endfunction

    function automatic void seal_list();
        int unsigned n;
        n = ext_body.size();
        ext_body.push_front(8'(n));
        ext_body.push_front(8'(n >> 8));
    endfunction

    task automatic send_word(logic [7:0] d, bit last);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        i_valid     <= 1'b1;
        i_data_byte <= d;
        i_is_last   <= last;
        do @(posedge i_clk); while (!o_ready);
        if (role_q) words_sent++;
        sni_predict_word(d, last);
    endtask

    task automatic send_body(bit with_last);
        foreach (ext_body[i]) send_word(ext_body[i], with_last && (i == ext_body.size() - 1));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_role(bit v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        role_q = v;
    endtask

    task automatic test_directed();
        // empty list
        ext_body = {8'h00, 8'h00};
        send_body(1'b1);
        // one short name
        ext_body.delete();
        put_record(8'h00, 2);
        seal_list();
        send_body(1'b1);
        // body ends inside the list length
        ext_body = {8'h00};
        send_body(1'b1);
        // fewer bytes than the list length promises
        ext_body = {8'h00, 8'h04, 8'h00, 8'h00, 8'h00};
        send_body(1'b1);
        ext_body = {8'hFF, 8'hFF, 8'h00};
        send_body(1'b1);
        // record length runs past the list end
        ext_body = {8'h00, 8'h04, 8'h01, 8'h00, 8'h05, 8'hA5};
        send_body(1'b1);
        // body ends inside a record header
        ext_body = {8'h00, 8'h02, 8'h00, 8'h00};
        send_body(1'b1);
    endtask

    task automatic test_record_positions();
        // empty and foreign-type records still take a position; count caps
        ext_body.delete();
        put_record(8'h00, 1);
        put_record(8'h00, 0);
        put_record(8'hFF, 2);
        put_record(8'h00, 1);
        put_record(8'h00, 1);
        put_record(8'h00, 1);
        seal_list();
        send_body(1'b1);
        ext_body.delete();
        repeat (5) put_record(8'h00, 0);
        seal_list();
        send_body(1'b1);
    endtask

    task automatic test_long_names();
        idle_pct  = 32;
        stall_pct = 32;
        // largest kept name size, then one byte over the limit; both bodies end early
        ext_body = {8'h00, 8'h06, 8'h00, 8'(NAME_LIMIT >> 8), 8'(NAME_LIMIT),
                    8'h11, 8'h22, 8'h33};
        send_body(1'b1);
        ext_body = {8'h00, 8'h05, 8'h00, 8'((NAME_LIMIT + 1) >> 8), 8'(NAME_LIMIT + 1),
                    8'hAB, 8'hCD};
        send_body(1'b1);
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    task automatic test_role_switch();
        logic [7:0] tail[$];
        write_role(1'b0);
        ext_body = {8'h12, 8'h34, 8'hFF};
        send_body(1'b1);
        // a last word in client role drops a half-parsed body
        write_role(1'b1);
        ext_body = {8'h00, 8'h07, 8'h00};
        send_body(1'b0);
        write_role(1'b0);
        ext_body = {8'h5A};
        send_body(1'b1);
        write_role(1'b1);
        ext_body = {8'h00, 8'h00};
        send_body(1'b1);
        // client-role words in the middle of a body leave the parse alone
        ext_body.delete();
        put_record(8'h00, 3);
        seal_list();
        tail     = ext_body[4:$];
        ext_body = ext_body[0:3];
        send_body(1'b0);
        write_role(1'b0);
        ext_body = {8'h00, 8'hC3, 8'h3C};
        send_body(1'b0);
        write_role(1'b1);
        ext_body = tail;
        send_body(1'b1);
    endtask

    task automatic random_body();
        int unsigned mode;
        int unsigned cut;
        ext_body.delete();
        repeat ($urandom_range(0, 6))
            put_record(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00,
                       ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12));
        seal_list();
        mode = $urandom_range(0, 99);
        if (mode < 10) begin
            ext_body[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
            send_body(1'b1);
        end else if (mode < 20) begin
            cut = $urandom_range(1, ext_body.size() - 1);
            ext_body = ext_body[0:cut-1];
            send_body(1'b1);
        end else if (mode < 25) begin
            ext_body.delete();
            repeat ($urandom_range(1, 10)) ext_body.push_back(8'($urandom));
            send_body(1'b1);
        end else if (mode < 29) begin
            write_role(1'b0);
            send_body($urandom_range(0, 1));
            write_role(1'b1);
        end else begin
            send_body(1'b1);
        end
    endtask

    task automatic test_random_bodies();
        int unsigned goal;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 55; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 55; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            goal = words_sent + RAND_WORDS / 4;
            while (words_sent < goal) random_body();
        end
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin : check_words
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got.kind         = t_kind'(o_kind);
            got.slot         = o_slot;
            got.byte_offset  = o_byte_offset;
            got.name_byte    = o_name_byte;
            got.name_size    = o_name_size;
            got.status       = t_status'(o_status);
            got.name_count   = o_name_count;
            got.count_capped = o_count_capped;
            got.final_result = o_final_result;
            if (expected_words.size() == 0) begin
                err_cnt++;
                if (err_cnt <= REPORT_MAX)
                    $display("%0t: unexpected result word kind=%0d slot=%0d status=%0d",
                             $realtime, got.kind, got.slot, got.status);
            end else begin
                want = expected_words.pop_front();
                if (got.kind !== want.kind || got.slot !== want.slot ||
                    got.byte_offset !== want.byte_offset || got.name_byte !== want.name_byte ||
                    got.name_size !== want.name_size || got.status !== want.status ||
                    got.name_count !== want.name_count ||
                    got.count_capped !== want.count_capped ||
                    got.final_result !== want.final_result) begin
                    err_cnt++;
                    if (err_cnt <= REPORT_MAX) begin
                        $display("%0t: result word mismatch", $realtime);
                        $display("  exp kind=%0d slot=%0d off=%0d byte=%h size=%0d",
                                 want.kind, want.slot, want.byte_offset, want.name_byte,
                                 want.name_size,
                                 " st=%0d cnt=%0d cap=%0d fin=%0d",
                                 want.status, want.name_count,
                                 want.count_capped, want.final_result);
                        $display("  got kind=%0d slot=%0d off=%0d byte=%h size=%0d",
                                 got.kind, got.slot, got.byte_offset, got.name_byte,
                                 got.name_size,
                                 " st=%0d cnt=%0d cap=%0d fin=%0d",
                                 got.status, got.name_count,
                                 got.count_capped, got.final_result);
                    end
                end
            end
        end
    end

    initial begin
        role_q = 1'b1;
        sni_clear_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_record_positions();
        test_role_switch();
        test_long_names();
        test_random_bodies();
        wait_idle();
        if (err_cnt == 0 && expected_words.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
